/* rtl/core/overlay_rle_palette_expand_macros.svh */
// Assertion macros shared by the overlay decoder checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef OVERLAY_RLE_PALETTE_EXPAND_MACROS_SVH
`define OVERLAY_RLE_PALETTE_EXPAND_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ORPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("overlay decoder check failed");

// Next-cycle implication, disabled while reset is low.
`define ORPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("overlay decoder check failed");

`endif

/* rtl/core/orpe_pkg.sv */
// Shared types and constants of the overlay run-length palette decoder.
// No dependencies; imported by the top level, orpe_convert and orpe_span.
package orpe_pkg;

	localparam int COORD_BITS = 12;
	localparam int CFG_BITS   = 12;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CFG_BITS-1:0]   cfg_word_t;

	localparam cfg_word_t MIN_WIDTH        = 12'd128;
	localparam cfg_word_t BT709_MIN_HEIGHT = 12'd600;
	localparam cfg_word_t WIDTH_RESET      = 12'd720;
	localparam cfg_word_t HEIGHT_RESET     = 12'd480;

	localparam logic FUNC_PALETTE = 1'b0;
	localparam logic FUNC_RUN     = 1'b1;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// Q16 conversion weights, luma and chroma scale folded in
	localparam logic [17:0] K_LUMA     = 18'd76309;
	localparam logic [17:0] K601_CR_R  = 18'd104597;
	localparam logic [17:0] K601_CB_G  = 18'd25675;
	localparam logic [17:0] K601_CR_G  = 18'd53279;
	localparam logic [17:0] K601_CB_B  = 18'd132201;
	localparam logic [17:0] K709_CR_R  = 18'd117489;
	localparam logic [17:0] K709_CB_G  = 18'd13975;
	localparam logic [17:0] K709_CR_G  = 18'd34925;
	localparam logic [17:0] K709_CB_B  = 18'd138438;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t len;
		logic   last;
		logic   done;
	} span_t;

endpackage

/* rtl/core/overlay_rle_palette_expand.sv */
// Top level of the overlay run-length decoder with a Y/Cb/Cr palette.
// Depends on orpe_pkg, orpe_convert and orpe_span.
//
// A palette write is taken in one beat, then the shared multiplier steps
// through five products and the entry is stored before the next beat is
// taken. A run takes its beat and then emits one span per cycle while the
// output register drains, holding the input until its last span is out;
// a zero-length run is taken and emits no span. The palette RAM has one
// write and one registered read port and needs no clearing pass after
// reset.
module overlay_rle_palette_expand import orpe_pkg::*; #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  luma,
	input  logic [7:0]  chroma_blue,
	input  logic [7:0]  chroma_red,
	input  logic [7:0]  transparency,
	input  logic [11:0] run_length,
	input  logic [7:0]  colour_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] span_x,
	output logic [11:0] span_y,
	output logic [11:0] span_len,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last,
	output logic        image_done
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_SPAN = 3'b100
	} state_t;

	state_t    state_q;
	cfg_word_t width_q;
	cfg_word_t height_q;
	logic      wr_ok_q;
	logic      oor_q;
	logic [AW-1:0] wr_addr_q;
	logic [7:0]    alpha_q;
	logic [31:0]   pal_rd_q;
	logic [31:0]   pal_mem [PALETTE_DEPTH];

	logic        out_valid_q;
	span_t       out_span_q;
	logic [31:0] out_colour_q;

	logic   accept;
	logic   conv_start;
	logic   conv_done;
	rgb_t   conv_rgb;
	logic   run_start;
	logic   adv;
	logic   out_free;
	logic   idx_ok;
	logic   pal_re;
	coord_t width_eff;
	coord_t height_eff;
	span_t  span;

	assign in_stall   = state_q != ST_IDLE;
	assign accept     = in_valid && !in_stall;
	assign conv_start = accept && (func == FUNC_PALETTE);
	assign run_start  = accept && (func == FUNC_RUN) && (run_length != '0);
	assign pal_re     = run_start;
	assign out_free   = !out_valid_q || !out_stall;
	assign adv        = (state_q == ST_SPAN) && out_free;

	assign idx_ok     = {1'b0, entry_index} < 9'(PALETTE_DEPTH);
	assign width_eff  = (width_q < MIN_WIDTH) ? MIN_WIDTH : width_q;
	assign height_eff = (height_q == '0) ? cfg_word_t'(1) : height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_wdata;
			end else if (cfg_index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (conv_start) begin
						state_q <= ST_CONV;
					end else if (run_start) begin
						state_q <= ST_SPAN;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SPAN: begin
					if (adv && span.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the entry index and alpha while the converter runs
	always_ff @(posedge clk) begin
		if (conv_start) begin
			wr_ok_q   <= idx_ok;
			wr_addr_q <= entry_index[AW-1:0];
			alpha_q   <= transparency;
		end
		if (run_start) begin
			oor_q <= {1'b0, colour_index} >= 9'(PALETTE_DEPTH);
		end
	end

	always_ff @(posedge clk) begin
		if (conv_done && wr_ok_q) begin
			pal_mem[wr_addr_q] <= {conv_rgb.r, conv_rgb.g, conv_rgb.b, alpha_q};
		end
		if (pal_re) begin
			pal_rd_q <= pal_mem[colour_index[AW-1:0]];
		end
	end

	orpe_convert u_convert (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (conv_start),
		.bt709       (height_q >= BT709_MIN_HEIGHT),
		.luma        (luma),
		.chroma_blue (chroma_blue),
		.chroma_red  (chroma_red),
		.done        (conv_done),
		.rgb         (conv_rgb)
	);

	orpe_span u_span (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (run_start),
		.run_len (run_length),
		.adv     (adv),
		.width   (width_eff),
		.height  (height_eff),
		.span    (span)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_span_q   <= span;
			out_colour_q <= oor_q ? '0 : pal_rd_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign span_x     = out_span_q.x;
	assign span_y     = out_span_q.y;
	assign span_len   = out_span_q.len;
	assign last       = out_span_q.last;
	assign image_done = out_span_q.done;
	assign red        = out_colour_q[31:24];
	assign green      = out_colour_q[23:16];
	assign blue       = out_colour_q[15:8];
	assign alpha      = out_colour_q[7:0];

endmodule

/* rtl/core/orpe_convert.sv */
// Palette entry converter: Y/Cb/Cr to clamped RGB over one shared multiplier.
// Depends on orpe_pkg for weights and the rgb_t type.
module orpe_convert import orpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       bt709,
	input  logic [7:0] luma,
	input  logic [7:0] chroma_blue,
	input  logic [7:0] chroma_red,
	output logic       done,
	output rgb_t       rgb
);

	localparam logic [2:0] STEP_LAST = 3'd5;

	logic               busy_q;
	logic               done_q;
	logic [2:0]         step_q;
	logic               bt709_q;
	logic signed [8:0]  ym_q;
	logic signed [8:0]  cb_q;
	logic signed [8:0]  cr_q;
	logic signed [27:0] prod_q;
	logic signed [27:0] sy_q;
	logic signed [29:0] gacc_q;
	rgb_t               rgb_q;

	logic [17:0]        coef;
	logic signed [8:0]  op;
	logic signed [18:0] coef_s;
	logic signed [27:0] product;
	logic signed [29:0] sum_add;
	logic signed [29:0] sum_sub;
	logic signed [29:0] sum_g;

	function automatic logic [7:0] clamp_q16(input logic signed [29:0] acc);
		logic [7:0] v;
		if (acc <= 30'sd0) begin
			v = '0;
		end else if (|acc[28:24]) begin
			v = 8'hFF;
		end else begin
			v = acc[23:16];
		end
		return v;
	endfunction

	// Product order: luma, Cr->R, Cb->G, Cr->G, Cb->B
	always_comb begin
		case (step_q)
			3'd0: begin
				coef = K_LUMA;
				op   = ym_q;
			end
			3'd1: begin
				coef = bt709_q ? K709_CR_R : K601_CR_R;
				op   = cr_q;
			end
			3'd2: begin
				coef = bt709_q ? K709_CB_G : K601_CB_G;
				op   = cb_q;
			end
			3'd3: begin
				coef = bt709_q ? K709_CR_G : K601_CR_G;
				op   = cr_q;
			end
			3'd4: begin
				coef = bt709_q ? K709_CB_B : K601_CB_B;
				op   = cb_q;
			end
			default: begin
				coef = '0;
				op   = '0;
			end
		endcase
	end

	assign coef_s  = $signed({1'b0, coef});
	assign product = coef_s * op;
	assign sum_add = 30'(sy_q) + 30'(prod_q);
	assign sum_sub = 30'(sy_q) - 30'(prod_q);
	assign sum_g   = gacc_q - 30'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bt709_q <= bt709;
			ym_q    <= $signed({1'b0, luma}) - 9'sd16;
			cb_q    <= $signed({1'b0, chroma_blue}) - 9'sd128;
			cr_q    <= $signed({1'b0, chroma_red}) - 9'sd128;
		end else if (busy_q) begin
			prod_q <= product;
			case (step_q)
				3'd1: sy_q <= prod_q;
				3'd2: rgb_q.r <= clamp_q16(sum_add);
				3'd3: gacc_q <= sum_sub;
				3'd4: rgb_q.g <= clamp_q16(sum_g);
				3'd5: rgb_q.b <= clamp_q16(sum_add);
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign rgb  = rgb_q;

endmodule

/* rtl/core/orpe_span.sv */
// Span sequencer: splits a run at row ends and tracks the paint position.
// Depends on orpe_pkg for coord_t and span_t.
module orpe_span import orpe_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  coord_t run_len,
	input  logic   adv,
	input  coord_t width,
	input  coord_t height,
	output span_t  span
);

	coord_t col_q;
	coord_t row_q;
	coord_t rem_q;

	coord_t                room;
	logic                  take_room;
	logic [COORD_BITS:0]   row_next;
	logic                  fin;
	coord_t                len;

	assign room      = width - col_q;
	assign take_room = rem_q >= room;
	assign row_next  = {1'b0, row_q} + {{COORD_BITS{1'b0}}, 1'b1};
	assign fin       = take_room && (row_next >= {1'b0, height});
	assign len       = take_room ? room : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rem_q <= '0;
		end else if (start) begin
			rem_q <= run_len;
			// drop back to the origin if a new size left us outside the image
			if (col_q >= width || row_q >= height) begin
				col_q <= '0;
				row_q <= '0;
			end
		end else if (adv) begin
			rem_q <= rem_q - len;
			if (take_room) begin
				col_q <= '0;
				row_q <= fin ? '0 : row_next[COORD_BITS-1:0];
			end else begin
				col_q <= col_q + len;
			end
		end
	end

	assign span.x    = col_q;
	assign span.y    = row_q;
	assign span.len  = len;
	assign span.last = (rem_q <= room) || fin;
	assign span.done = fin;

endmodule

/* rtl/core/orpe_checker.sv */
// Port-level checks of the overlay decoder, bound to the top level.
// Depends on overlay_rle_palette_expand_macros.svh.
`include "overlay_rle_palette_expand_macros.svh"

module orpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] span_x,
	input logic [11:0] span_y,
	input logic [11:0] span_len,
	input logic        last,
	input logic        image_done
);

	logic [12:0] span_end;

	assign span_end = {1'b0, span_x} + {1'b0, span_len};

	// hold a stalled beat
	`ORPE_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(span_x) && $stable(span_y) && $stable(span_len))
	`ORPE_ASSERT_NOW(a_len_nonzero, clk, arst_n, out_valid, span_len != 12'd0)
	`ORPE_ASSERT_NOW(a_done_is_last, clk, arst_n, out_valid && image_done, last)
	// a span never runs past the widest row
	`ORPE_ASSERT_NOW(a_in_row, clk, arst_n, out_valid, span_end <= 13'd4095)

endmodule

bind overlay_rle_palette_expand orpe_checker u_orpe_checker (.*);
